// ===== hw/rtl/debounced_button_led_mode_sequencer_unit_defines.svh =====
// Assertion macros for the file that checks its own logic.
// Each use expects clk_i and rst_ni to be in scope.
`ifndef DEBOUNCED_BUTTON_LED_MODE_SEQUENCER_UNIT_DEFINES_SVH
`define DEBOUNCED_BUTTON_LED_MODE_SEQUENCER_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define DBLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define DBLMS_ASSERT_NEVER(lbl, expr, msg) \
  `DBLMS_ASSERT(lbl, !(expr), msg)

`endif

// ===== hw/rtl/dblms_pkg.sv =====
`default_nettype none

package dblms_pkg;

  // Field widths.
  localparam int unsigned IntegW  = 8;
  localparam int unsigned WindowW = 16;
  localparam int unsigned TallyW  = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned NumModes = 4;

  // Register reset values.
  localparam logic [IntegW-1:0]  DebounceRst = 8'd10;
  localparam logic [WindowW-1:0] WindowRst   = 16'd100;
  localparam logic [TimerW-1:0]  FastRst     = 16'd250;
  localparam logic [TimerW-1:0]  SlowRst     = 16'd1000;

  // The press tally saturates here.
  localparam logic [TallyW-1:0] TallyMax = 3'd7;

  // Phase count of the blink modes; rotation modes wrap at four naturally.
  localparam logic [PhaseW-1:0] BlinkPhases = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_LIMIT   = 8'd0,
    CFG_CLICK_WINDOW     = 8'd1,
    CFG_FAST_PHASE_LIMIT = 8'd2,
    CFG_SLOW_PHASE_LIMIT = 8'd3
  } cfg_idx_e;

  // Display modes.
  typedef enum logic [ModeW-1:0] {
    MODE_ROTATE_A = 2'd0,
    MODE_BLINK_OR = 2'd1,
    MODE_BLINK_BL = 2'd2,
    MODE_ROTATE_B = 2'd3
  } mode_e;

  // Click classification of one tick.
  typedef struct packed {
    logic single_click;
    logic double_click;
  } click_t;

  // LED drive of one tick.
  typedef struct packed {
    logic green;
    logic orange;
    logic red;
    logic blue;
  } led_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dblms_click.sv =====
`default_nettype none

module dblms_click import dblms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               level_i,
  input  logic [IntegW-1:0]  debounce_limit_i,
  input  logic [WindowW-1:0] click_window_i,
  output click_t             click_o
);

  logic [IntegW-1:0]  integ_q, integ_d;
  logic               pressed_q, pressed_d;
  logic [WindowW-1:0] window_q, window_d;
  logic [TallyW-1:0]  tally_q, tally_d;

  // Debounce, click window and classification for the current item.
  always_comb begin
    logic [WindowW-1:0] win_dec;
    logic [TallyW-1:0]  tally_mid;
    integ_d   = integ_q;
    pressed_d = pressed_q;
    tally_mid = tally_q;
    click_o   = '0;

    win_dec  = (window_q != '0) ? window_q - WindowW'(1) : window_q;
    window_d = win_dec;

    if (level_i) begin
      if (integ_q < debounce_limit_i) begin
        integ_d = integ_q + IntegW'(1);
      end else if (!pressed_q) begin
        if (win_dec == '0) begin
          window_d = click_window_i;
        end
        if (tally_q < TallyMax) begin
          tally_mid = tally_q + TallyW'(1);
        end
        pressed_d = 1'b1;
      end
    end else begin
      if (integ_q != '0) begin
        integ_d = integ_q - IntegW'(1);
      end else begin
        pressed_d = 1'b0;
      end
    end

    tally_d = tally_mid;
    if (window_d == '0 && tally_mid != '0) begin
      if (tally_mid > TallyW'(1)) begin
        click_o.double_click = 1'b1;
      end else begin
        click_o.single_click = 1'b1;
      end
      tally_d = '0;
    end
  end

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      pressed_q <= 1'b0;
      window_q  <= '0;
      tally_q   <= '0;
    end else if (step_i) begin
      integ_q   <= integ_d;
      pressed_q <= pressed_d;
      window_q  <= window_d;
      tally_q   <= tally_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dblms_display.sv =====
`default_nettype none

module dblms_display import dblms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  click_t            click_i,
  input  logic [TimerW-1:0] fast_limit_i,
  input  logic [TimerW-1:0] slow_limit_i,
  output logic [ModeW-1:0]  mode_next_o,
  output logic [ModeW-1:0]  mode_cur_o,
  output led_t              led_o
);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic [TimerW-1:0] timer_q [NumModes];
  logic [PhaseW-1:0] phase_q [NumModes];
  logic [TimerW-1:0] timer_d;
  logic [PhaseW-1:0] phase_d;

  // Mode advance, active timer and LED decode.
  always_comb begin
    logic              rotation;
    logic [TimerW-1:0] limit;
    logic [PhaseW-1:0] ph_inc;
    mode_d = click_i.single_click ? mode_q + ModeW'(1) : mode_q;

    rotation = (mode_e'(mode_d) == MODE_ROTATE_A) || (mode_e'(mode_d) == MODE_ROTATE_B);
    limit    = rotation ? fast_limit_i : slow_limit_i;
    ph_inc   = phase_q[mode_d] + PhaseW'(1);

    if (timer_q[mode_d] >= limit) begin
      timer_d = '0;
      if (!rotation && ph_inc >= BlinkPhases) begin
        ph_inc = '0;
      end
      phase_d = ph_inc;
    end else begin
      timer_d = timer_q[mode_d] + TimerW'(1);
      phase_d = phase_q[mode_d];
    end

    led_o = '0;
    unique case (mode_e'(mode_d))
      MODE_ROTATE_A: begin
        case (phase_d)
          2'd0:    led_o.red    = 1'b1;
          2'd1:    led_o.blue   = 1'b1;
          2'd2:    led_o.green  = 1'b1;
          default: led_o.orange = 1'b1;
        endcase
      end
      MODE_BLINK_OR: led_o.orange = (phase_d == '0);
      MODE_BLINK_BL: led_o.blue   = (phase_d == '0);
      MODE_ROTATE_B: begin
        case (phase_d)
          2'd0:    led_o.red    = 1'b1;
          2'd1:    led_o.green  = 1'b1;
          2'd2:    led_o.blue   = 1'b1;
          default: led_o.orange = 1'b1;
        endcase
      end
      default: led_o = '0;
    endcase
  end

  assign mode_next_o = mode_d;
  assign mode_cur_o  = mode_q;

  // Only the active mode's timer and phase are written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      for (int i = 0; i < NumModes; i++) begin
        timer_q[i] <= '0;
        phase_q[i] <= '0;
      end
    end else if (step_i) begin
      mode_q          <= mode_d;
      timer_q[mode_d] <= timer_d;
      phase_q[mode_d] <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/debounced_button_led_mode_sequencer_unit.sv =====
// Debounced button with single and double click detection driving a four-LED
// mode display. Each input item is one 1 ms tick with the raw button level;
// each item gives exactly one result item with the LED drive, the click flags
// and the display mode in use after that tick. An item enters an input
// register, is processed combinationally and lands in the result register,
// so one item per clock cycle is sustained while the output is not stalled.
// The four limit registers are written through the configuration port, which
// is always ready; index 0 is the debounce limit, 1 the click window, 2 the
// fast and 3 the slow phase limit, and other indexes are ignored.
`default_nettype none

`include "debounced_button_led_mode_sequencer_unit_defines.svh"

module debounced_button_led_mode_sequencer_unit import dblms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Tick items.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               button_level_i,
  // Result items.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               led_green_o,
  output logic               led_orange_o,
  output logic               led_red_o,
  output logic               led_blue_o,
  output logic               single_click_o,
  output logic               double_click_o,
  output logic [ModeW-1:0]   active_mode_o,
  // Configuration writes.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  logic [IntegW-1:0]  debounce_limit_q;
  logic [WindowW-1:0] click_window_q;
  logic [TimerW-1:0]  fast_limit_q;
  logic [TimerW-1:0]  slow_limit_q;

  logic       in_valid_q;
  logic       level_q;
  logic       out_valid_q;
  logic       advance;
  logic       step;
  click_t     click;
  led_t       led;
  logic [ModeW-1:0] mode_next;
  logic [ModeW-1:0] mode_cur;
  click_t     click_q;
  led_t       led_q;
  logic [ModeW-1:0] mode_out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_limit_q <= DebounceRst;
      click_window_q   <= WindowRst;
      fast_limit_q     <= FastRst;
      slow_limit_q     <= SlowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE_LIMIT:   debounce_limit_q <= cfg_data_i[IntegW-1:0];
        CFG_CLICK_WINDOW:     click_window_q   <= cfg_data_i;
        CFG_FAST_PHASE_LIMIT: fast_limit_q     <= cfg_data_i;
        CFG_SLOW_PHASE_LIMIT: slow_limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is free or being emptied.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      level_q <= button_level_i;
    end
  end

  dblms_click u_click (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .level_i          (level_q),
    .debounce_limit_i (debounce_limit_q),
    .click_window_i   (click_window_q),
    .click_o          (click)
  );

  dblms_display u_display (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .click_i      (click),
    .fast_limit_i (fast_limit_q),
    .slow_limit_i (slow_limit_q),
    .mode_next_o  (mode_next),
    .mode_cur_o   (mode_cur),
    .led_o        (led)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      click_q    <= click;
      led_q      <= led;
      mode_out_q <= mode_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_green_o    = led_q.green;
  assign led_orange_o   = led_q.orange;
  assign led_red_o      = led_q.red;
  assign led_blue_o     = led_q.blue;
  assign single_click_o = click_q.single_click;
  assign double_click_o = click_q.double_click;
  assign active_mode_o  = mode_out_q;

  // Checks on the processing path.
  `DBLMS_ASSERT_NEVER(a_click_exclusive, step && click.single_click && click.double_click,
    "single and double click flagged on the same tick")
  `DBLMS_ASSERT(a_single_advances_mode, step && click.single_click |=> mode_cur == $past(mode_cur) + 2'd1,
    "single click did not advance the display mode")
  `DBLMS_ASSERT(a_mode_holds_when_idle, !step |=> $stable(mode_cur),
    "display mode changed without an item")
  `DBLMS_ASSERT(a_stall_needs_item, in_stall_o |-> in_valid_q && out_valid_q,
    "input stalled with nothing held")

endmodule

`default_nettype wire
